// File: hw/rtl/bbn_pkg.sv
// Shared types for the bounding box normalizer.
// Holds the controller state encoding and the command and status bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbn_pkg;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_EXTENT  = 9'b000000010,
        S_LONGEST = 9'b000000100,
        S_CLAMP   = 9'b000001000,
        S_OFFSET  = 9'b000010000,
        S_SCALE   = 9'b000100000,
        S_DIVIDE  = 9'b001000000,
        S_ROUND   = 9'b010000000,
        S_EMIT    = 9'b100000000
    } t_state;

    typedef struct packed {
        logic capture;
        logic measure;
        logic extent;
        logic longest;
        logic clamp;
        logic offset;
        logic scale;
        logic div_step;
        logic round;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic ready;
        logic len_zero;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: hw/rtl/bbn_ctrl.sv
// Sequencer for the bounding box normalizer.
// Steps the datapath through extent, offset, divide and round phases.
// Depends on bbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbn_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire                 i_rescale_pass,
    output logic                o_stall,
    input  bbn_pkg::t_status    i_status,
    output bbn_pkg::t_cmd       o_cmd
);

    bbn_pkg::t_state r_state;
    bbn_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            bbn_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_rescale_pass) begin
                        o_cmd.capture = 1'b1;
                        n_state = i_status.ready ? bbn_pkg::S_CLAMP : bbn_pkg::S_EXTENT;
                    end else begin
                        o_cmd.measure = 1'b1;
                    end
                end
            end
            bbn_pkg::S_EXTENT: begin
                o_cmd.extent = 1'b1;
                n_state = bbn_pkg::S_LONGEST;
            end
            bbn_pkg::S_LONGEST: begin
                o_cmd.longest = 1'b1;
                n_state = bbn_pkg::S_CLAMP;
            end
            bbn_pkg::S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state = bbn_pkg::S_OFFSET;
            end
            bbn_pkg::S_OFFSET: begin
                o_cmd.offset = 1'b1;
                n_state = bbn_pkg::S_SCALE;
            end
            bbn_pkg::S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state = i_status.len_zero ? bbn_pkg::S_EMIT : bbn_pkg::S_DIVIDE;
            end
            bbn_pkg::S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = bbn_pkg::S_ROUND;
                end
            end
            bbn_pkg::S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state = bbn_pkg::S_EMIT;
            end
            bbn_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = bbn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bbn_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/bbn_datapath.sv
// Datapath for the bounding box normalizer: bounds, longest extent,
// per-axis offset, three bit-serial dividers and the output register.
// Depends on bbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbn_datapath #(
    parameter int unsigned CW = 32,
    parameter int unsigned FB = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  bbn_pkg::t_cmd           i_cmd,
    output bbn_pkg::t_status        o_status,
    input  wire signed [CW-1:0]     i_coord_x,
    input  wire signed [CW-1:0]     i_coord_y,
    input  wire signed [CW-1:0]     i_coord_z,
    input  wire                     i_first_vertex,
    input  wire                     i_stall,
    output logic                    o_valid,
    output logic [FB-1:0]           o_norm_x,
    output logic [FB-1:0]           o_norm_y,
    output logic [FB-1:0]           o_norm_z,
    output logic                    o_degenerate
);

    localparam int unsigned NW    = CW + 1;
    localparam int unsigned RW    = CW + 4;
    localparam int unsigned CNT_W = $clog2(FB);
    localparam logic [FB-1:0] ONE_14 = FB'(((1 << FB) + 7) / 14);

    logic [CW-1:0]    w_v [3];
    logic [CW-1:0]    r_v [3];
    logic [CW-1:0]    r_lo [3];
    logic [CW-1:0]    r_hi [3];
    logic [CW-1:0]    r_ext [3];
    logic [CW-1:0]    r_diff [3];
    logic [NW-1:0]    r_n [3];
    logic [RW-1:0]    r_rem [3];
    logic [FB-1:0]    r_q [3];
    logic [RW-1:0]    n_rem [3];
    logic [FB-1:0]    n_q [3];
    logic [FB-1:0]    n_qr [3];
    logic [CW-1:0]    r_len;
    logic [RW-1:0]    r_d;
    logic [RW-1:0]    r_l7;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ready;
    logic             r_valid;
    logic [CW-1:0]    w_max01;

    // offset binary so unsigned compare follows signed order
    assign w_v[0] = {~i_coord_x[CW-1], i_coord_x[CW-2:0]};
    assign w_v[1] = {~i_coord_y[CW-1], i_coord_y[CW-2:0]};
    assign w_v[2] = {~i_coord_z[CW-1], i_coord_z[CW-2:0]};

    assign w_max01 = (r_ext[0] > r_ext[1]) ? r_ext[0] : r_ext[1];

    always_comb begin
        logic [RW:0] sh;
        logic        ge;
        logic        up;
        for (int k = 0; k < 3; k++) begin
            sh       = {r_rem[k], 1'b0};
            ge       = (sh >= {1'b0, r_d});
            n_rem[k] = ge ? RW'(sh - {1'b0, r_d}) : RW'(sh);
            n_q[k]   = {r_q[k][FB-2:0], ge};
            up       = (({1'b0, r_rem[k]} + {1'b0, r_l7}) >= {1'b0, r_d});
            n_qr[k]  = r_q[k] + FB'(up);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= '0;
                r_hi[k] <= '0;
            end
            r_len   <= '0;
            r_ready <= 1'b0;
        end else begin
            if (i_cmd.measure) begin
                for (int k = 0; k < 3; k++) begin
                    if (i_first_vertex) begin
                        r_lo[k] <= w_v[k];
                        r_hi[k] <= w_v[k];
                    end else begin
                        if (w_v[k] < r_lo[k]) begin
                            r_lo[k] <= w_v[k];
                        end
                        if (w_v[k] > r_hi[k]) begin
                            r_hi[k] <= w_v[k];
                        end
                    end
                end
                r_ready <= 1'b0;
            end
            if (i_cmd.longest) begin
                r_len   <= (w_max01 > r_ext[2]) ? w_max01 : r_ext[2];
                r_ready <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int k = 0; k < 3; k++) begin
                r_v[k] <= w_v[k];
            end
        end
        if (i_cmd.extent) begin
            for (int k = 0; k < 3; k++) begin
                r_ext[k] <= r_hi[k] - r_lo[k];
            end
        end
        if (i_cmd.clamp) begin
            for (int k = 0; k < 3; k++) begin
                if (r_v[k] < r_lo[k]) begin
                    r_diff[k] <= '0;
                end else if (r_v[k] > r_hi[k]) begin
                    r_diff[k] <= r_ext[k];
                end else begin
                    r_diff[k] <= r_v[k] - r_lo[k];
                end
            end
        end
        if (i_cmd.offset) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= {r_diff[k], 1'b0} + NW'(r_len - r_ext[k]);
            end
            r_d  <= RW'({r_len, 4'b0}) - RW'({r_len, 1'b0});
            r_l7 <= RW'({r_len, 3'b0}) - RW'(r_len);
        end
        if (i_cmd.scale) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= RW'({r_n[k], 2'b0}) + RW'({r_n[k], 1'b0}) + RW'(r_len);
                r_q[k]   <= '0;
            end
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
            end
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.round) begin
            for (int k = 0; k < 3; k++) begin
                r_q[k] <= n_qr[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_norm_x     <= (r_len == '0) ? ONE_14 : r_q[0];
            o_norm_y     <= (r_len == '0) ? ONE_14 : r_q[1];
            o_norm_z     <= (r_len == '0) ? ONE_14 : r_q[2];
            o_degenerate <= (r_len == '0);
        end
    end

    assign o_valid           = r_valid;
    assign o_status.ready    = r_ready;
    assign o_status.len_zero = (r_len == '0);
    assign o_status.div_last = (r_cnt == CNT_W'(FB - 1));
    assign o_status.out_free = !r_valid || !i_stall;

endmodule

`default_nettype wire

// File: hw/rtl/bounding_box_normalize.sv
// Normalizes a vertex set into the unit cube using its bounding box.
// Top level: joins bbn_ctrl and bbn_datapath. Depends on bbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Send every vertex twice: first with rescale_pass low to measure the box
// (first_vertex high on the first one), then with rescale_pass high to get
// one normalized vertex per transaction. A measure transaction leaves the
// controller idle, so the next one is taken without a stall. A rescale
// transaction stalls the input through the clamp, offset, scale, divide,
// round and emit steps; the bit-serial dividers produce one quotient bit
// per cycle on all three axes. The first rescale transaction after reset
// or after a measure also passes the extent and longest steps to latch the
// longest extent. A degenerate box (zero extent) skips the divide and round
// steps. The result sits in an output register, so the next transaction is
// taken while it waits to be consumed; a result that is still held when the
// next one is ready delays it until the held one is taken.
module bounding_box_normalize #(
    parameter int unsigned COORD_WIDTH   = 32,
    parameter int unsigned OUT_FRAC_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire signed [COORD_WIDTH-1:0] i_coord_x,
    input  wire signed [COORD_WIDTH-1:0] i_coord_y,
    input  wire signed [COORD_WIDTH-1:0] i_coord_z,
    input  wire                          i_rescale_pass,
    input  wire                          i_first_vertex,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [OUT_FRAC_BITS-1:0]     o_norm_x,
    output logic [OUT_FRAC_BITS-1:0]     o_norm_y,
    output logic [OUT_FRAC_BITS-1:0]     o_norm_z,
    output logic                         o_degenerate
);

    bbn_pkg::t_cmd    w_cmd;
    bbn_pkg::t_status w_status;

    bbn_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_rescale_pass (i_rescale_pass),
        .o_stall        (o_stall),
        .i_status       (w_status),
        .o_cmd          (w_cmd)
    );

    bbn_datapath #(
        .CW (COORD_WIDTH),
        .FB (OUT_FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_first_vertex (i_first_vertex),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_norm_x       (o_norm_x),
        .o_norm_y       (o_norm_y),
        .o_norm_z       (o_norm_z),
        .o_degenerate   (o_degenerate)
    );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for bounding_box_normalize: random valid/stall traffic,
// vertex sets sent as a measure pass and then a rescale pass, results scored in order.
// Depends only on the bounding_box_normalize RTL and its package.
`timescale 1ns / 1ps

module testbench;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam logic [CW-1:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [CW-1:0] COORD_MIN = 32'h8000_0000;
    localparam logic [CW-1:0] COORD_MAX = 32'h7fff_ffff;
    localparam logic [FB-1:0] ONE_FOURTEENTH = FB'(((1 << FB) + 7) / 14);
    localparam logic MEASURE = 1'b0;
    localparam logic RESCALE = 1'b1;
    localparam int TARGET_ITEMS = 1950;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 60;

    typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_FLAT, SPREAD_CORNER} t_spread;

    typedef struct packed {
        logic [2:0][CW-1:0] coord;
        logic               rescale;
        logic               first;
        logic               drain;
    } t_xact;

    typedef struct packed {
        logic [2:0][FB-1:0] norm;
        logic               degen;
    } t_norm;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            i_stall = 1'b0;
    logic [CW-1:0]   i_coord_x = '0;
    logic [CW-1:0]   i_coord_y = '0;
    logic [CW-1:0]   i_coord_z = '0;
    logic            i_rescale_pass = 1'b0;
    logic            i_first_vertex = 1'b0;
    logic            o_stall;
    logic            o_valid;
    logic [FB-1:0]   o_norm_x;
    logic [FB-1:0]   o_norm_y;
    logic [FB-1:0]   o_norm_z;
    logic            o_degenerate;

    bounding_box_normalize #(
        .COORD_WIDTH  (CW),
        .OUT_FRAC_BITS(FB)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_rescale_pass(i_rescale_pass),
        .i_first_vertex(i_first_vertex),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_norm_x      (o_norm_x),
        .o_norm_y      (o_norm_y),
        .o_norm_z      (o_norm_z),
        .o_degenerate  (o_degenerate)
    );

    t_xact         pending_vertices[$];
    t_norm         expected_norms[$];
    logic [CW-1:0] box_low[3];
    logic [CW-1:0] box_high[3];
    logic [CW-1:0] longest = '0;
    logic          longest_held = 1'b0;
    logic          in_took = 1'b0;
    logic          calm = 1'b0;
    int            send_gap = 0;
    int            stall_left = 0;
    int            queued = 0;
    int            mismatches = 0;
    int            measures_seen = 0;
    int            norms_checked = 0;
    int            degens_checked = 0;
    int            cycle_count = 0;

    initial begin
        for (int k = 0; k < 3; k++) begin
            box_low[k] = '0;
            box_high[k] = '0;
        end
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Bounds kept in offset binary so unsigned compares follow signed order.
    function automatic bit predict_norm(input t_xact t, output t_norm res);
        logic [CW-1:0] v, lo, hi, c, e, d;
        logic [63:0]   n, q, len;
        int            k;
        res = '0;
        if (t.rescale == MEASURE) begin
            for (k = 0; k < 3; k++) begin
                v = t.coord[k] ^ SIGN_BIT;
                if (t.first) begin
                    box_low[k] = v;
                    box_high[k] = v;
                end else begin
                    if (v < box_low[k]) box_low[k] = v;
                    if (v > box_high[k]) box_high[k] = v;
                end
            end
            longest_held = 1'b0;
            return 1'b0;
        end
        if (!longest_held) begin
            longest = '0;
            for (k = 0; k < 3; k++) begin
                e = box_high[k] - box_low[k];
                if (e > longest) longest = e;
            end
            longest_held = 1'b1;
        end
        if (longest == '0) begin
            for (k = 0; k < 3; k++) res.norm[k] = ONE_FOURTEENTH;
            res.degen = 1'b1;
            return 1'b1;
        end
        len = {32'b0, longest};
        for (k = 0; k < 3; k++) begin
            lo = box_low[k];
            hi = box_high[k];
            c = t.coord[k] ^ SIGN_BIT;
            if (c < lo) c = lo;
            if (c > hi) c = hi;
            e = hi - lo;
            d = c - lo;
            n = 2 * {32'b0, d} + len - {32'b0, e};
            q = (((6 * n + len) << FB) + 7 * len) / (14 * len);
            res.norm[k] = q[FB-1:0];
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CW-1:0] pick_coord(t_spread mode, logic [CW-1:0] base,
                                                 logic [CW-1:0] spread);
        case (mode)
            SPREAD_FULL:   return $urandom;
            SPREAD_NARROW: return base + ($urandom & spread);
            SPREAD_FLAT:   return base;
            default: begin
                case ($urandom_range(0, 4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return '0;
                    3: return '1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic queue_item(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic [CW-1:0] z, input logic rescale,
                              input logic first, input logic drain);
        t_xact t;
        t.coord[0] = x;
        t.coord[1] = y;
        t.coord[2] = z;
        t.rescale = rescale;
        t.first = first;
        t.drain = drain;
        pending_vertices.push_back(t);
        queued++;
    endtask

    // One vertex set: measure pass then rescale pass, sometimes with a stray vertex.
    task automatic queue_set();
        t_xact         verts[$];
        t_xact         t;
        t_spread       mode[3];
        logic [CW-1:0] base[3];
        logic [CW-1:0] spread[3];
        int            n, k, i;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (k = 0; k < 3; k++) begin
            mode[k] = t_spread'($urandom_range(0, 3));
            base[k] = $urandom;
            spread[k] = 32'hffff_ffff >> $urandom_range(0, 31);
        end
        for (i = 0; i < n; i++) begin
            for (k = 0; k < 3; k++) t.coord[k] = pick_coord(mode[k], base[k], spread[k]);
            verts.push_back(t);
        end
        for (i = 0; i < n; i++)
            queue_item(verts[i].coord[0], verts[i].coord[1], verts[i].coord[2], MEASURE,
                       i == 0, i == 0 && $urandom_range(0, 7) == 0);
        for (i = 0; i < n; i++)
            queue_item(verts[i].coord[0], verts[i].coord[1], verts[i].coord[2], RESCALE,
                       1'($urandom_range(0, 1)), 1'b0);
        if ($urandom_range(0, 3) == 0)
            queue_item($urandom, $urandom, $urandom, RESCALE, 1'($urandom_range(0, 1)),
                       1'b0);
    endtask

    task automatic queue_noise();
        int i;
        for (i = $urandom_range(1, 4); i > 0; i--)
            queue_item($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    endtask

    always @(negedge i_clk) begin : driver
        t_xact nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_took) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_vertices.size() != 0 &&
                         !(pending_vertices[0].drain && expected_norms.size() != 0)) begin
                nxt = pending_vertices.pop_front();
                i_coord_x <= nxt.coord[0];
                i_coord_y <= nxt.coord[1];
                i_coord_z <= nxt.coord[2];
                i_rescale_pass <= nxt.rescale;
                i_first_vertex <= nxt.first;
                i_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if ($urandom_range(0, 299) == 0) calm <= !calm;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin : monitor
        t_xact seen;
        t_norm want;
        t_norm got;
        in_took <= i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.norm[0] = o_norm_x;
                got.norm[1] = o_norm_y;
                got.norm[2] = o_norm_z;
                got.degen = o_degenerate;
                if (expected_norms.size() == 0) begin
                    flag_mismatch("result with none pending, norm_x", 64'd0,
                                  64'(got.norm[0]));
                end else begin
                    want = expected_norms.pop_front();
                    for (int k = 0; k < 3; k++)
                        if (got.norm[k] !== want.norm[k])
                            flag_mismatch($sformatf("norm axis %0d", k), 64'(want.norm[k]),
                                          64'(got.norm[k]));
                    if (got.degen !== want.degen)
                        flag_mismatch("degenerate", 64'(want.degen), 64'(got.degen));
                    norms_checked++;
                    if (want.degen) degens_checked++;
                end
            end
            if (i_valid && !o_stall) begin
                seen.coord[0] = i_coord_x;
                seen.coord[1] = i_coord_y;
                seen.coord[2] = i_coord_z;
                seen.rescale = i_rescale_pass;
                seen.first = i_first_vertex;
                seen.drain = 1'b0;
                if (predict_norm(seen, want)) expected_norms.push_back(want);
                else measures_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        // rescale before any box is measured, first_vertex ignored
        queue_item(32'd1, 32'd2, 32'd3, RESCALE, 1'b1, 1'b0);
        queue_item(COORD_MAX, COORD_MIN, '0, RESCALE, 1'b0, 1'b0);
        // single-vertex box
        queue_item(32'h0005_0000, 32'hfffd_0000, '0, MEASURE, 1'b1, 1'b0);
        queue_item(32'h0005_0000, 32'hfffd_0000, '0, RESCALE, 1'b0, 1'b0);
        // full-range box, clamping of outside vertices
        queue_item(COORD_MIN, '0, 32'd100, MEASURE, 1'b1, 1'b0);
        queue_item(COORD_MAX, 32'd1, -32'sd100, MEASURE, 1'b0, 1'b0);
        queue_item(COORD_MIN, '0, 32'd100, RESCALE, 1'b0, 1'b0);
        queue_item(COORD_MAX, 32'd1, -32'sd100, RESCALE, 1'b0, 1'b0);
        queue_item('0, '0, '0, RESCALE, 1'b0, 1'b0);
        queue_item(COORD_MIN, COORD_MAX, COORD_MIN, RESCALE, 1'b0, 1'b0);
        queue_item(COORD_MAX, '1, 32'd1000, RESCALE, 1'b1, 1'b0);
        // widen the old box without a first marker
        queue_item('0, 32'd50, '0, MEASURE, 1'b0, 1'b1);
        queue_item('0, 32'd50, '0, RESCALE, 1'b0, 1'b0);
        // flat box
        queue_item('1, '1, '1, MEASURE, 1'b1, 1'b0);
        queue_item('1, '1, '1, MEASURE, 1'b0, 1'b0);
        queue_item('1, '1, '1, RESCALE, 1'b0, 1'b0);
        // smallest nonzero extent
        queue_item('0, '0, '0, MEASURE, 1'b1, 1'b1);
        queue_item(32'd1, '0, '0, MEASURE, 1'b0, 1'b0);
        queue_item('0, '0, '0, RESCALE, 1'b0, 1'b0);
        queue_item(32'd1, '0, '0, RESCALE, 1'b0, 1'b0);
        while (queued < TARGET_ITEMS) begin
            if ($urandom_range(0, 4) == 0) queue_noise();
            else queue_set();
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_vertices.size() != 0 || i_valid || expected_norms.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d box-measuring transactions; checked %0d normalized vertices,",
                 measures_seen, norms_checked);
        $display("%0d of them degenerate.", degens_checked);
        if (mismatches == 0 && expected_norms.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
